// ----- rtl/core/csq_pkg.sv -----
// Shared types and constants for the counting semaphore wait queue unit.
// Used by csq_ring and counting_semaphore_wait_queue_unit; depends on nothing.
package csq_pkg;

    localparam int QUEUE_DEPTH = 10;
    localparam int SLOT_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int WAITERS_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W        = 16;
    localparam int COUNT_W     = 16;

    localparam logic [SLOT_W-1:0]    SLOT_LAST    = SLOT_W'(QUEUE_DEPTH - 1);
    localparam logic [WAITERS_W-1:0] WAITERS_FULL = WAITERS_W'(QUEUE_DEPTH);
    localparam logic [COUNT_W-1:0]   COUNT_MAX    = {COUNT_W{1'b1}};

    typedef enum logic [2:0] {
        KIND_WAIT     = 3'd0,
        KIND_TRYWAIT  = 3'd1,
        KIND_POST     = 3'd2,
        KIND_DESTROY  = 3'd3,
        KIND_GETVALUE = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_ERROR       = 3'd1,
        ST_WOULD_BLOCK = 3'd2,
        ST_NOT_OWNER   = 3'd3,
        ST_BLOCKED     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        REG_OWNER_ENV     = 2'd0,
        REG_SHARED_FLAG   = 2'd1,
        REG_INITIAL_COUNT = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic [ID_W-1:0]   wdata;
        logic              re;
        logic [SLOT_W-1:0] raddr;
    } ring_req_t;

endpackage

// ----- rtl/core/csq_ring.sv -----
// Wait ring memory: one write port, one read port, registered read data.
// Depends on csq_pkg for depth, slot width and the request struct.
module csq_ring (
    input  logic                   clk,
    input  csq_pkg::ring_req_t     req,
    output logic [csq_pkg::ID_W-1:0] rdata
);
    import csq_pkg::*;

    logic [ID_W-1:0] mem [QUEUE_DEPTH];
    logic [ID_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/counting_semaphore_wait_queue_unit.sv -----
// Counting semaphore with a FIFO ring of waiting thread ids.
// Request input stream (s_*), result output stream (m_*), APB register port.
// Depends on csq_pkg and csq_ring.
//
// Usage:
//   Each request item on s_* carries kind in s_tuser and the caller thread
//   and environment in s_tdata; exactly one result item leaves on m_* with
//   status in m_tuser and wake flag, woken thread and count in m_tdata.
//   m_tvalid rises in the cycle after input acceptance. Throughput is
//   one item per cycle: a new item is taken in the same cycle that the
//   pending result is taken. A post that releases a waiter reads the ring
//   memory at acceptance; the woken id appears from the registered read port
//   together with the result.
//   The receiver may stall m_tready indefinitely; the result holds and
//   s_tready stays low until it is taken.
//   Reset empties the queue, clears count and registers and marks the
//   semaphore valid. Registers at 0x0 owner_env, 0x4 shared_flag,
//   0x8 initial_count; write initial_count only while no item is pending.
module counting_semaphore_wait_queue_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // caller_thread[15:0], caller_env[31:16]
    input  logic [2:0]  s_tuser,   // kind[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // wake_valid[0], wake_thread[16:1], count_value[32:17]
    output logic [2:0]  m_tuser,   // status[2:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import csq_pkg::*;

    logic [15:0]          owner_env_reg;
    logic                 shared_flag_reg;
    logic [COUNT_W-1:0]   initial_count_reg;

    logic [COUNT_W-1:0]   count_reg, count_next;
    logic                 valid_reg, valid_next;
    logic [WAITERS_W-1:0] waiters_reg, waiters_next;
    logic [SLOT_W-1:0]    enq_slot_reg, enq_slot_next;
    logic [SLOT_W-1:0]    deq_slot_reg, deq_slot_next;

    logic                 out_valid_reg;
    status_t              status_reg, status_next;
    logic                 wake_valid_reg, wake_valid_next;
    logic [COUNT_W-1:0]   count_value_reg, count_value_next;

    ring_req_t            ring_req;
    logic [ID_W-1:0]      ring_rdata;

    logic                 in_fire;
    logic                 cfg_write;
    logic [1:0]           cfg_index;
    logic [ID_W-1:0]      caller_thread;
    logic [15:0]          caller_env;
    kind_t                kind;

    assign pready        = 1'b1;
    assign cfg_write     = psel && penable && pwrite;
    assign cfg_index     = paddr[3:2];
    assign caller_thread = s_tdata[15:0];
    assign caller_env    = s_tdata[31:16];
    assign kind          = kind_t'(s_tuser);

    assign s_tready = !out_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    always_comb
    begin
        case (reg_index_t'(cfg_index))
            REG_OWNER_ENV:     prdata = {16'd0, owner_env_reg};
            REG_SHARED_FLAG:   prdata = {31'd0, shared_flag_reg};
            REG_INITIAL_COUNT: prdata = {16'd0, initial_count_reg};
            default:           prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        count_next       = count_reg;
        valid_next       = valid_reg;
        waiters_next     = waiters_reg;
        enq_slot_next    = enq_slot_reg;
        deq_slot_next    = deq_slot_reg;
        status_next      = ST_ERROR;
        wake_valid_next  = 1'b0;
        count_value_next = '0;
        ring_req.we      = 1'b0;
        ring_req.waddr   = enq_slot_reg;
        ring_req.wdata   = caller_thread;
        ring_req.re      = 1'b0;
        ring_req.raddr   = deq_slot_reg;

        if (kind == KIND_DESTROY)
        begin
            if (caller_env != owner_env_reg && !shared_flag_reg)
            begin
                status_next = ST_NOT_OWNER;
            end
            else
            begin
                valid_next  = 1'b0;
                status_next = ST_OK;
            end
        end
        else if (valid_reg)
        begin
            case (kind)
                KIND_WAIT, KIND_TRYWAIT:
                begin
                    if (count_reg != '0)
                    begin
                        count_next  = count_reg - 1'b1;
                        status_next = ST_OK;
                    end
                    else if (kind == KIND_TRYWAIT)
                    begin
                        status_next = ST_WOULD_BLOCK;
                    end
                    else if (waiters_reg >= WAITERS_FULL)
                    begin
                        status_next = ST_ERROR;
                    end
                    else
                    begin
                        ring_req.we   = in_fire;
                        enq_slot_next = (enq_slot_reg == SLOT_LAST) ? '0 : enq_slot_reg + 1'b1;
                        waiters_next  = waiters_reg + 1'b1;
                        status_next   = ST_BLOCKED;
                    end
                end
                KIND_POST:
                begin
                    status_next = ST_OK;
                    if (count_reg != '0 || waiters_reg == '0)
                    begin
                        if (count_reg != COUNT_MAX)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        ring_req.re     = in_fire;
                        waiters_next    = waiters_reg - 1'b1;
                        deq_slot_next   = (deq_slot_reg == SLOT_LAST) ? '0 : deq_slot_reg + 1'b1;
                        wake_valid_next = 1'b1;
                    end
                end
                KIND_GETVALUE:
                begin
                    count_value_next = count_reg;
                    status_next      = ST_OK;
                end
                default:
                begin
                    status_next = ST_ERROR;
                end
            endcase
        end
    end

    csq_ring u_ring (
        .clk   (clk),
        .req   (ring_req),
        .rdata (ring_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owner_env_reg     <= '0;
            shared_flag_reg   <= 1'b0;
            initial_count_reg <= '0;
            count_reg         <= '0;
            valid_reg         <= 1'b1;
            waiters_reg       <= '0;
            enq_slot_reg      <= '0;
            deq_slot_reg      <= '0;
            out_valid_reg     <= 1'b0;
            status_reg        <= ST_OK;
            wake_valid_reg    <= 1'b0;
            count_value_reg   <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                count_reg       <= count_next;
                valid_reg       <= valid_next;
                waiters_reg     <= waiters_next;
                enq_slot_reg    <= enq_slot_next;
                deq_slot_reg    <= deq_slot_next;
                out_valid_reg   <= 1'b1;
                status_reg      <= status_next;
                wake_valid_reg  <= wake_valid_next;
                count_value_reg <= count_value_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_write)
            begin
                case (reg_index_t'(cfg_index))
                    REG_OWNER_ENV:
                    begin
                        owner_env_reg <= pwdata[15:0];
                    end
                    REG_SHARED_FLAG:
                    begin
                        shared_flag_reg <= pwdata[0];
                    end
                    REG_INITIAL_COUNT:
                    begin
                        initial_count_reg <= pwdata[15:0];
                        count_reg         <= pwdata[15:0];
                        waiters_reg       <= '0;
                        enq_slot_reg      <= '0;
                        deq_slot_reg      <= '0;
                        valid_reg         <= 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {7'd0, count_value_reg,
                       (wake_valid_reg ? ring_rdata : {ID_W{1'b0}}), wake_valid_reg};

endmodule
